>>> rtl/lbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED breathing PWM package
// Shared item codes, register indexes, constants and state types.
// ----------------------------------------------------------------------------
package lbp_pkg;

    // Item kinds carried on the input channel.
    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_START = 2'd1,
        KIND_STOP  = 2'd2
    } t_kind;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_STEP_TICKS = 1'b0,
        CFG_OFF_LEVEL  = 1'b1
    } t_cfg_index;

    localparam logic [15:0] STEP_TICKS_RESET = 16'd1920;

    // Hold count derivation from the requested period.
    localparam int unsigned HOLD_UNIT_MS     = 250;
    localparam logic [7:0]  DEFAULT_HOLD     = 8'd2;   // 1000 ms / 2 / 250
    // floor(x / 250) == (x * RECIP_250) >> RECIP_SHIFT for any 15-bit x.
    localparam int unsigned RECIP_SHIFT      = 23;
    localparam logic [15:0] RECIP_250        = 16'd33555;

    // Phase sequencing state that moves at every phase end.
    typedef struct packed {
        logic       lit;        // 1 while the pin sits at the lit level
        logic [7:0] duty;
        logic       dir_down;
        logic [8:0] hold_cnt;
    } t_phase_st;

endpackage

>>> rtl/lbp_hold_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED breathing PWM hold decode
// Turns a requested breathing period into the number of duty holds.
// ----------------------------------------------------------------------------
module lbp_hold_decode (
    input  logic [15:0] i_breath_ms,
    output logic [7:0]  o_hold_limit
);
    import lbp_pkg::*;

    logic [14:0] half;
    logic [30:0] recip_prod;
    logic [7:0]  quot;
    logic [15:0] back_prod;
    logic        exact;

    // Half the period divided by 250 through a reciprocal multiply.
    assign half       = i_breath_ms[15:1];
    assign recip_prod = 31'(half) * 31'(RECIP_250);
    assign quot       = recip_prod[RECIP_SHIFT +: 8];

    // The half period must be a whole, nonzero number of hold units.
    assign back_prod  = 16'(quot) * 16'(HOLD_UNIT_MS);
    assign exact      = (back_prod[14:0] == half);

    assign o_hold_limit = ((quot != 8'd0) && exact) ? quot : DEFAULT_HOLD;

endmodule

>>> rtl/led_breathing_pwm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED breathing PWM
// Triangle-duty software PWM that makes an LED fade up and down.
// ----------------------------------------------------------------------------
// Usage:
//   Each input beat is a clock tick of the PWM timebase, a start command
//   (with the breathing period in ms) or a stop command. Every accepted beat
//   produces exactly one result beat carrying the pin level, the running flag
//   and the current duty index after that beat has been applied.
//   A beat is accepted when i_valid is high and o_stall is low; a result is
//   taken when o_valid is high and i_stall is low.
//   The result of a beat is registered in the result register, or in the
//   skid register while the receiver stalls. A beat is accepted every cycle
//   unless o_stall is high; all work lies between state and result registers.
//   When the receiver stalls, the result register holds and a one-entry skid
//   register absorbs the next result, so o_stall rises only once both hold a
//   beat and falls as soon as the receiver takes one.
//   Reset (i_rst_n low, synchronous) stops breathing, sets the duty to one,
//   clears the lit flag, empties both result registers and loads
//   the default step length. The configuration port is always ready; writes
//   are expected only while no beat is in flight.
// ----------------------------------------------------------------------------
module led_breathing_pwm #(
    parameter int unsigned DUTY_STEPS = 250
) (
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_kind,
    input  logic [15:0]         i_breath_ms,

    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_led_pin,
    output logic                o_running,
    output logic [7:0]          o_duty,

    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  lbp_pkg::t_cfg_index i_cfg_index,
    input  logic [15:0]         i_cfg_data
);
    import lbp_pkg::*;

    localparam logic [7:0] DutyMax = 8'(DUTY_STEPS);

    // Configuration registers.
    logic [15:0] r_step_ticks;
    logic        r_off_level;

    // Breathing state. The pin is kept as a lit/dark flag so that a change
    // of the off level keeps the meaning of the running phase.
    logic [23:0] r_phase, n_phase;
    t_phase_st   r_ps, n_ps;
    logic [7:0]  r_hold_limit, n_hold_limit;
    logic        r_active, n_active;

    // Result register and skid register.
    logic        r_out_valid;
    logic        r_out_pin, r_out_run;
    logic [7:0]  r_out_duty;
    logic        r_skid_valid;
    logic        r_skid_pin, r_skid_run;
    logic [7:0]  r_skid_duty;

    logic        in_accept;
    logic        out_free;
    logic [7:0]  start_hold;
    logic [15:0] step_len;
    logic [23:0] phase_dec;
    t_phase_st   end_one, end_two, end_fin;
    logic        skip_empty;
    logic [7:0]  phase_factor;
    logic [23:0] phase_prod;
    logic        res_pin;

    // One phase end: count it, move the duty after every full hold, and
    // flip between the lit and the dark phase.
    function automatic t_phase_st f_end_phase(t_phase_st s, logic [7:0] hold_lim,
                                              logic [7:0] duty_max);
        t_phase_st  r;
        logic [8:0] cnt;
        r   = s;
        cnt = s.hold_cnt + 9'd1;
        r.hold_cnt = cnt;
        if (cnt >= {hold_lim, 1'b0}) begin
            r.hold_cnt = 9'd1;
            if (s.duty >= duty_max) begin
                r.dir_down = 1'b1;
            end else if (s.duty <= 8'd1) begin
                r.dir_down = 1'b0;
            end
            r.duty = r.dir_down ? (s.duty - 8'd1) : (s.duty + 8'd1);
        end
        r.lit = ~s.lit;
        return r;
    endfunction

    lbp_hold_decode u_hold_decode (
        .i_breath_ms  (i_breath_ms),
        .o_hold_limit (start_hold)
    );

    assign o_stall     = r_skid_valid;
    assign in_accept   = i_valid && !r_skid_valid;
    assign out_free    = !r_out_valid || !i_stall;
    assign o_cfg_ready = 1'b1;

    // A zero step length behaves as one tick per step.
    assign step_len  = (r_step_ticks == 16'd0) ? 16'd1 : r_step_ticks;
    assign phase_dec = (r_phase != 24'd0) ? (r_phase - 24'd1) : 24'd0;

    // At full duty the dark phase has no length: it ends in the same tick,
    // so a second phase end follows directly. Only then can a new phase be
    // empty, which lets a single multiplier size the final phase.
    assign end_one      = f_end_phase(r_ps, r_hold_limit, DutyMax);
    assign skip_empty   = !end_one.lit && (end_one.duty == DutyMax);
    assign end_two      = f_end_phase(end_one, r_hold_limit, DutyMax);
    assign end_fin      = skip_empty ? end_two : end_one;
    assign phase_factor = end_fin.lit ? end_fin.duty : (DutyMax - end_fin.duty);
    assign phase_prod   = 24'(phase_factor) * 24'(step_len);

    always_comb begin
        n_phase      = r_phase;
        n_ps         = r_ps;
        n_hold_limit = r_hold_limit;
        n_active     = r_active;
        if (in_accept) begin
            case (i_kind)
                KIND_START: begin
                    n_hold_limit = start_hold;
                    n_ps.hold_cnt = 9'd0;
                    n_ps.duty     = 8'd1;
                    n_ps.dir_down = 1'b0;
                    n_ps.lit      = 1'b1;
                    n_active      = 1'b1;
                    n_phase       = 24'(step_len);
                end
                KIND_STOP: begin
                    n_active = 1'b0;
                    n_ps.lit = 1'b0;
                end
                KIND_TICK: begin
                    if (r_active) begin
                        if (phase_dec == 24'd0) begin
                            n_ps    = end_fin;
                            n_phase = phase_prod;
                        end else begin
                            n_phase = phase_dec;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign res_pin = r_off_level ^ n_ps.lit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_ticks  <= STEP_TICKS_RESET;
            r_off_level   <= 1'b0;
            r_phase       <= 24'd0;
            r_ps.lit      <= 1'b0;
            r_ps.duty     <= 8'd1;
            r_ps.dir_down <= 1'b0;
            r_ps.hold_cnt <= 9'd0;
            r_hold_limit  <= 8'd0;
            r_active      <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_ps         <= n_ps;
            r_hold_limit <= n_hold_limit;
            r_active     <= n_active;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_STEP_TICKS: r_step_ticks <= i_cfg_data;
                    CFG_OFF_LEVEL:  r_off_level  <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Result register with a skid stage behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || in_accept;
            r_skid_valid <= r_skid_valid && in_accept;
        end else if (in_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out_pin  <= r_skid_pin;
                r_out_run  <= r_skid_run;
                r_out_duty <= r_skid_duty;
            end else if (in_accept) begin
                r_out_pin  <= res_pin;
                r_out_run  <= n_active;
                r_out_duty <= n_ps.duty;
            end
        end
        if (in_accept && (r_skid_valid || !out_free)) begin
            r_skid_pin  <= res_pin;
            r_skid_run  <= n_active;
            r_skid_duty <= n_ps.duty;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_led_pin = r_out_pin;
    assign o_running = r_out_run;
    assign o_duty    = r_out_duty;

    // A running sequence always has a phase in progress.
    a_phase_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_phase != 24'd0))
        else $error("running with an empty phase");

    // The duty bounces within its range, from 1 up to DutyMax inclusive.
    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ps.duty >= 8'd1) && (r_ps.duty <= DutyMax))
        else $error("duty out of range");

    // The skid register is only filled behind a held result.
    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a beat while the result register is empty");

    // Breathing always runs with a nonzero hold count.
    a_hold_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_hold_limit != 8'd0))
        else $error("running without a hold count");

endmodule
